FILE: rtl/core/pc_pkg.sv
// Package with the shared types and constants of the Pearson correlation block.
package pc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int RESULT_BITS = 16;
    localparam int MAX_PAIRS_DEFAULT = 65536;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_sample;
        logic signed [SAMPLE_BITS-1:0] y_sample;
        logic                          last_pair;
    } pc_in_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] correlation;
        logic                          status;
    } pc_out_t;

endpackage

FILE: rtl/core/pc_accum.sv
// Running count and sums of one run of sample pairs.
module pc_accum
    import pc_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT,
    parameter int CW = $clog2(MAX_PAIRS + 1),
    parameter int SW = SAMPLE_BITS + CW,
    parameter int QW = 2 * SAMPLE_BITS - 1 + CW,
    parameter int PW = 2 * SAMPLE_BITS + CW
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       add_en,
    input  logic                       clear,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] y,
    output logic [CW-1:0]              count,
    output logic signed [SW-1:0]       sum_x,
    output logic signed [SW-1:0]       sum_y,
    output logic [QW-1:0]              sum_xx,
    output logic [QW-1:0]              sum_yy,
    output logic signed [PW-1:0]       sum_xy
);

    logic [CW-1:0]              count_reg;
    logic signed [SW-1:0]       sum_x_reg, sum_y_reg;
    logic [QW-1:0]              sum_xx_reg, sum_yy_reg;
    logic signed [PW-1:0]       sum_xy_reg;
    logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;
    logic                       room;

    assign xx = x * x;
    assign yy = y * y;
    assign xy = x * y;
    assign room = (count_reg < CW'(MAX_PAIRS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (clear)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (add_en && room)
        begin
            count_reg  <= count_reg + 1'b1;
            sum_x_reg  <= sum_x_reg + SW'(x);
            sum_y_reg  <= sum_y_reg + SW'(y);
            sum_xx_reg <= sum_xx_reg + QW'($unsigned(xx));
            sum_yy_reg <= sum_yy_reg + QW'($unsigned(yy));
            sum_xy_reg <= sum_xy_reg + PW'(xy);
        end
    end

    assign count  = count_reg;
    assign sum_x  = sum_x_reg;
    assign sum_y  = sum_y_reg;
    assign sum_xx = sum_xx_reg;
    assign sum_yy = sum_yy_reg;
    assign sum_xy = sum_xy_reg;

endmodule

FILE: rtl/core/pc_mul.sv
// Shared shift-and-add multiplier, one multiplier bit per cycle, modulo 2^W.
module pc_mul
    import pc_pkg::*;
#(
    parameter int W  = 166,
    parameter int BW = 66
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [W-1:0]  product
);

    logic          busy_reg;
    logic [W-1:0]  acc_reg, a_reg;
    logic [BW-1:0] b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            acc_reg  <= '0;
            a_reg    <= a;
            b_reg    <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_reg + (b_reg[0] ? a_reg : '0);
                a_reg   <= a_reg << 1;
                b_reg   <= b_reg >> 1;
            end
        end
    end

    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

endmodule

FILE: rtl/core/pearson_correlation.sv
// Pearson correlation top level: sequencer around the accumulator and shared multiplier.
//
// Pairs are taken one per cycle while the block is idle; the pair marked last starts the
// final computation, during which the input is not ready. All products run through one
// shift-and-add multiplier that retires one multiplier bit per cycle. Seven products build
// the variances, covariance and their product, one more squares the covariance, then a
// binary search of up to 16 steps over the result code needs two more products per step.
// A zero-variance run finishes after the seventh product; otherwise the length of the final
// computation is set by the bit lengths of the count, the running sums and the variances and
// by the result code. The result waits in an output register until taken. Status 1 reports
// zero variance with a correlation of zero.
module pearson_correlation
    import pc_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  pc_in_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output pc_out_t out_data
);

    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int QW  = 2 * SAMPLE_BITS - 1 + CW;
    localparam int PW  = 2 * SAMPLE_BITS + CW;
    localparam int BW0 = 2 * (SAMPLE_BITS + CW);
    localparam int BW  = (BW0 > 32) ? BW0 : 32;
    localparam int W   = 2 * BW + 34;

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_OUT} state_t;
    typedef enum logic [3:0] {
        OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NSXY, OP_SXSY,
        OP_VXVY, OP_MAG, OP_TT, OP_RHS
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [W-1:0]  tmp_reg, tmp_next, num_reg, num_next, prod_reg, prod_next;
    logic [W-1:0]  lhs_reg, lhs_next;
    logic [BW-1:0] vx_reg, vx_next, vy_reg, vy_next, mag_reg, mag_next;
    logic [31:0]   t2_reg, t2_next;
    logic [15:0]   lo_reg, lo_next, hi_reg, hi_next;
    pc_out_t       res_reg, res_next;

    logic                 accept;
    logic [CW-1:0]        count;
    logic signed [SW-1:0] sum_x, sum_y;
    logic [QW-1:0]        sum_xx, sum_yy;
    logic signed [PW-1:0] sum_xy;
    logic [SW-1:0]        sx_abs, sy_abs;
    logic [W-1:0]         a_sel;
    logic [BW-1:0]        b_sel;
    logic                 mul_start, mul_done;
    logic [W-1:0]         product;
    logic [16:0]          mid_sum;
    logic [15:0]          mid, t;
    logic [15:0]          lo_new, hi_new;

    assign accept = in_valid && in_ready;

    pc_accum #(
        .MAX_PAIRS(MAX_PAIRS), .CW(CW), .SW(SW), .QW(QW), .PW(PW)
    ) u_accum (
        .clk(clk), .rst_n(rst_n),
        .add_en(accept), .clear(state_reg == ST_OUT),
        .x(in_data.x_sample), .y(in_data.y_sample),
        .count(count), .sum_x(sum_x), .sum_y(sum_y),
        .sum_xx(sum_xx), .sum_yy(sum_yy), .sum_xy(sum_xy)
    );

    pc_mul #(.W(W), .BW(BW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(a_sel), .b(b_sel), .done(mul_done), .product(product)
    );

    assign sx_abs  = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
    assign sy_abs  = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
    assign mid_sum = 17'(lo_reg) + 17'(hi_reg) + 17'd1;
    assign mid     = mid_sum[16:1];
    assign t       = 16'((mid << 1) - 16'd1);

    // Operand selection for the shared multiplier; signed factors keep the multiplier
    // operand as a magnitude and carry the sign in the multiplicand.
    always_comb
    begin
        a_sel = '0;
        b_sel = '0;
        case (op_reg)
            OP_NSXX: begin a_sel = W'(sum_xx);  b_sel = BW'(count);  end
            OP_SXSX: begin a_sel = W'(sx_abs);  b_sel = BW'(sx_abs); end
            OP_NSYY: begin a_sel = W'(sum_yy);  b_sel = BW'(count);  end
            OP_SYSY: begin a_sel = W'(sy_abs);  b_sel = BW'(sy_abs); end
            OP_NSXY: begin a_sel = W'(sum_xy);  b_sel = BW'(count);  end
            OP_SXSY:
            begin
                a_sel = sum_y[SW-1] ? W'(-sum_x) : W'(sum_x);
                b_sel = BW'(sy_abs);
            end
            OP_VXVY: begin a_sel = W'(vx_reg);  b_sel = vy_reg;      end
            OP_MAG:  begin a_sel = W'(mag_reg); b_sel = mag_reg;     end
            OP_TT:   begin a_sel = W'(t);       b_sel = BW'(t);      end
            OP_RHS:  begin a_sel = prod_reg;    b_sel = BW'(t2_reg); end
            default: begin a_sel = '0;          b_sel = '0;          end
        endcase
    end

    assign mul_start = (state_reg == ST_START);
    assign lo_new    = (lhs_reg >= product) ? mid : lo_reg;
    assign hi_new    = (lhs_reg >= product) ? hi_reg : 16'(mid - 16'd1);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        tmp_next   = tmp_reg;
        num_next   = num_reg;
        prod_next  = prod_reg;
        lhs_next   = lhs_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        mag_next   = mag_reg;
        t2_next    = t2_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.last_pair)
                begin
                    op_next    = OP_NSXX;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_START;
                    case (op_reg)
                        OP_NSXX: begin tmp_next = product; op_next = OP_SXSX; end
                        OP_SXSX:
                        begin
                            vx_next = BW'(tmp_reg - product);
                            op_next = OP_NSYY;
                        end
                        OP_NSYY: begin tmp_next = product; op_next = OP_SYSY; end
                        OP_SYSY:
                        begin
                            vy_next = BW'(tmp_reg - product);
                            op_next = OP_NSXY;
                        end
                        OP_NSXY: begin tmp_next = product; op_next = OP_SXSY; end
                        OP_SXSY:
                        begin
                            num_next = tmp_reg - product;
                            mag_next = num_next[W-1] ? BW'(-num_next) : BW'(num_next);
                            op_next  = OP_VXVY;
                        end
                        OP_VXVY:
                        begin
                            prod_next = product;
                            if (vx_reg == '0 || vy_reg == '0)
                            begin
                                res_next.correlation = '0;
                                res_next.status      = 1'b1;
                                state_next           = ST_OUT;
                            end
                            else
                            begin
                                op_next = OP_MAG;
                            end
                        end
                        OP_MAG:
                        begin
                            lhs_next = product << 32;
                            lo_next  = '0;
                            hi_next  = 16'd32768;
                            op_next  = OP_TT;
                        end
                        OP_TT:
                        begin
                            t2_next = product[31:0];
                            op_next = OP_RHS;
                        end
                        OP_RHS:
                        begin
                            lo_next = lo_new;
                            hi_next = hi_new;
                            if (lo_new < hi_new)
                            begin
                                op_next = OP_TT;
                            end
                            else
                            begin
                                res_next.status = 1'b0;
                                if (num_reg[W-1])
                                    res_next.correlation = 16'(16'd0 - lo_new);
                                else if (lo_new > 16'd32767)
                                    res_next.correlation = 16'd32767;
                                else
                                    res_next.correlation = lo_new;
                                state_next = ST_OUT;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NSXX;
            tmp_reg   <= '0;
            num_reg   <= '0;
            prod_reg  <= '0;
            lhs_reg   <= '0;
            vx_reg    <= '0;
            vy_reg    <= '0;
            mag_reg   <= '0;
            t2_reg    <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            tmp_reg   <= tmp_next;
            num_reg   <= num_next;
            prod_reg  <= prod_next;
            lhs_reg   <= lhs_next;
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            mag_reg   <= mag_next;
            t2_reg    <= t2_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            res_reg   <= res_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = res_reg;

endmodule

FILE: dv/tb_pearson_correlation.sv
// Self-checking testbench for the Pearson correlation block with a bit-exact predictor.
module tb_pearson_correlation;
    import pc_pkg::*;

    localparam int  HALF_PERIOD   = 2;
    localparam int  RESET_CYCLES  = 7;
    localparam int  RUN_LATENCY   = 1600;
    localparam int  LONG_HOLD     = 3000;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct {
        pc_in_t pair;
        bit     drain_first;
    } queued_pair_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    pc_in_t  in_data;
    logic    out_valid;
    logic    out_ready;
    pc_out_t out_data;

    pearson_correlation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    queued_pair_t pair_queue[$];
    pc_out_t      corr_expected[$];

    // Running sums of the current data set, held exactly.
    longint run_count;
    longint acc_x;
    longint acc_y;
    longint acc_xx;
    longint acc_yy;
    longint acc_xy;

    int     error_count;
    int     results_seen;
    int     zero_var_seen;
    int     saturated_seen;
    int     pairs_accepted;
    longint cycle_count;
    int     burst_left;
    int     gap_left;
    int     hold_left;
    bit     long_hold_done;
    logic [7:0] stall_pattern;
    int     pattern_left;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic pc_out_t correlation_of_run();
        logic signed [255:0] n_w;
        logic signed [255:0] sx_w;
        logic signed [255:0] sy_w;
        logic signed [255:0] vx_w;
        logic signed [255:0] vy_w;
        logic signed [255:0] cov_w;
        logic signed [255:0] prod_w;
        logic signed [255:0] mag_w;
        logic signed [255:0] lhs_w;
        logic signed [255:0] rhs_w;
        logic signed [255:0] sq_w;
        longint              t;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         mid;
        pc_out_t             r;
        n_w    = run_count;
        sx_w   = acc_x;
        sy_w   = acc_y;
        sq_w   = acc_xx;
        vx_w   = n_w * sq_w - sx_w * sx_w;
        sq_w   = acc_yy;
        vy_w   = n_w * sq_w - sy_w * sy_w;
        sq_w   = acc_xy;
        cov_w  = n_w * sq_w - sx_w * sy_w;
        prod_w = vx_w * vy_w;
        r = '0;
        if (prod_w == 0)
        begin
            r.status = 1'b1;
            return r;
        end
        mag_w = (cov_w < 0) ? -cov_w : cov_w;
        lhs_w = (mag_w * mag_w) <<< 32;
        lo = 0;
        hi = 32768;
        // Largest code k with (k - 1/2) <= 32768 * |r|, i.e. round half away from zero.
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * longint'(mid) - 1;
            sq_w = t * t;
            rhs_w = sq_w * prod_w;
            if (lhs_w >= rhs_w)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (cov_w < 0)
            r.correlation = 16'(65536 - lo);
        else
            r.correlation = (lo > 32767) ? 16'sd32767 : 16'(lo);
        return r;
    endfunction

    // Accumulates one pair; a marked pair returns 1 and the coefficient of its data set.
    function automatic bit accumulate_pair(input pc_in_t p, output pc_out_t r);
        longint x;
        longint y;
        x = longint'($signed(p.x_sample));
        y = longint'($signed(p.y_sample));
        r = '0;
        if (run_count < MAX_PAIRS_DEFAULT)
        begin
            run_count++;
            acc_x  += x;
            acc_y  += y;
            acc_xx += x * x;
            acc_yy += y * y;
            acc_xy += x * y;
        end
        if (!p.last_pair)
            return 1'b0;
        r = correlation_of_run();
        run_count = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xx = 0;
        acc_yy = 0;
        acc_xy = 0;
        return 1'b1;
    endfunction

    task automatic push_pair(input int x, input int y, input bit last, input bit drain);
        queued_pair_t q;
        q.pair.x_sample  = 16'(x);
        q.pair.y_sample  = 16'(y);
        q.pair.last_pair = last;
        q.drain_first    = drain;
        pair_queue.push_back(q);
    endtask

    task automatic push_random_run(input int len);
        int mode;
        int span;
        int x;
        int y;
        int c;
        mode = $urandom_range(0, 5);
        span = 1 << $urandom_range(1, 16);
        c = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++)
        begin
            x = $urandom_range(0, span - 1) - span / 2;
            case (mode)
                0: y = $urandom_range(0, 65535) - 32768;
                1: y = x + $urandom_range(0, 15) - 8;
                2: y = -x + $urandom_range(0, 3);
                3: y = c;
                4: y = $urandom_range(0, span - 1) - span / 2;
                default: y = 3 * x - 5;
            endcase
            if (mode == 0)
                x = $urandom_range(0, 65535) - 32768;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            push_pair(x, y, i == len - 1, 1'b0);
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pair_queue.size() > 0 && !(pair_queue[0].drain_first &&
                     (corr_expected.size() > 0 || (in_valid && in_data.last_pair))))
            begin
                in_data  <= pair_queue.pop_front().pair;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: a rotating stall pattern, plus one long hold while results back up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
            stall_pattern  <= 8'hFF;
            pattern_left   <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else if (!long_hold_done && results_seen == 3)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_ready      <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                pattern_left  <= $urandom_range(50, 2000);
            end
            else
            begin
                stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
                pattern_left  <= pattern_left - 1;
            end
            out_ready <= stall_pattern[0];
        end
    end

    // Monitor: predicts on accepted pairs and checks accepted results in order.
    always @(posedge clk)
    begin
        pc_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pairs_accepted++;
                if (accumulate_pair(in_data, want))
                    corr_expected.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (corr_expected.size() == 0)
                begin
                    $error("result with no expected transaction: correlation %0d status %0b",
                           out_data.correlation, out_data.status);
                    error_count++;
                end
                else
                begin
                    want = corr_expected.pop_front();
                    results_seen++;
                    if (want.status)
                        zero_var_seen++;
                    if (!want.status && want.correlation == 16'sd32767)
                        saturated_seen++;
                    if (out_data.correlation !== want.correlation)
                    begin
                        $error("correlation: expected %0d, actual %0d",
                               want.correlation, $signed(out_data.correlation));
                        error_count++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0b, actual %0b", want.status,
                               out_data.status);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL pearson_correlation");
            $finish;
        end
    end

    initial
    begin
        int queued;
        run_count = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xx = 0;
        acc_yy = 0;
        acc_xy = 0;
        error_count = 0;
        results_seen = 0;
        zero_var_seen = 0;
        saturated_seen = 0;
        pairs_accepted = 0;
        cycle_count = 0;
        rst_n = 1'b0;

        // Perfect positive correlation at the extremes saturates to just below one.
        push_pair(32767, 32767, 1'b0, 1'b0);
        push_pair(-32768, -32768, 1'b1, 1'b0);
        // Perfect negative correlation gives minus one exactly.
        push_pair(32767, -32768, 1'b0, 1'b0);
        push_pair(-32768, 32767, 1'b1, 1'b0);
        // A single pair always has zero variance.
        push_pair(-32768, 32767, 1'b1, 1'b0);
        // Constant x with varying y.
        push_pair(5, 1, 1'b0, 1'b0);
        push_pair(5, -7, 1'b0, 1'b0);
        push_pair(5, 300, 1'b1, 1'b0);
        // Uncorrelated square pattern.
        push_pair(1, 1, 1'b0, 1'b0);
        push_pair(-1, 1, 1'b0, 1'b0);
        push_pair(1, -1, 1'b0, 1'b0);
        push_pair(-1, -1, 1'b1, 1'b0);
        // Small imperfect correlation with zero samples.
        push_pair(0, 0, 1'b0, 1'b0);
        push_pair(1, 2, 1'b0, 1'b0);
        push_pair(2, 1, 1'b0, 1'b0);
        push_pair(3, 3, 1'b1, 1'b1);

        queued = pair_queue.size();
        while (queued < 1950)
        begin
            int len;
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = $urandom_range(60, 200);
                default: len = $urandom_range(2, 30);
            endcase
            push_random_run(len);
            // Now and then the sender waits for the block to go quiet first.
            if ($urandom_range(0, 15) == 0)
                pair_queue[queued].drain_first = 1'b1;
            queued = pair_queue.size();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n = 1'b1;

        while (pair_queue.size() > 0 || in_valid)
            @(posedge clk);
        while (corr_expected.size() > 0)
            @(posedge clk);
        repeat (RUN_LATENCY) @(posedge clk);

        $display("Ran %0d pairs into %0d data sets of mixed length and shape.",
                 pairs_accepted, results_seen);
        $display("Zero-variance results: %0d, saturated at plus one: %0d.",
                 zero_var_seen, saturated_seen);
        if (error_count == 0 && corr_expected.size() == 0)
            $display("PASS pearson_correlation");
        else
            $display("FAIL pearson_correlation");
        $finish;
    end

endmodule
